### rtl/msghe_pkg.sv
// shared types and constants for the messagepack header encoder
package msghe_pkg;

    // longest encoding: one tag byte and eight value bytes
    localparam int MAX_BYTES = 9;
    localparam int BUF_W     = MAX_BYTES * 8;
    localparam int CNT_W     = 4;

    // item operations
    typedef enum logic [2:0] {
        OP_STR = 3'd0,
        OP_BIN = 3'd1,
        OP_INT = 3'd2,
        OP_ARR = 3'd3,
        OP_RAW = 3'd4
    } t_opcode;

    // format tags
    localparam logic [7:0] TAG_FIXSTR   = 8'hA0;
    localparam logic [7:0] TAG_STR8     = 8'hD9;
    localparam logic [7:0] TAG_STR16    = 8'hDA;
    localparam logic [7:0] TAG_STR32    = 8'hDB;
    localparam logic [7:0] TAG_BIN8     = 8'hC4;
    localparam logic [7:0] TAG_BIN16    = 8'hC5;
    localparam logic [7:0] TAG_BIN32    = 8'hC6;
    localparam logic [7:0] TAG_INT8     = 8'hD0;
    localparam logic [7:0] TAG_INT16    = 8'hD1;
    localparam logic [7:0] TAG_INT32    = 8'hD2;
    localparam logic [7:0] TAG_INT64    = 8'hD3;
    localparam logic [7:0] TAG_FIXARRAY = 8'h90;
    localparam logic [7:0] TAG_ARRAY16  = 8'hDC;
    localparam logic [7:0] TAG_ARRAY32  = 8'hDD;

    // encoded item: byte count and bytes, first byte in the top lane
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [BUF_W-1:0] bytes;
    } t_enc;

endpackage

### rtl/msghe_encode.sv
// combinational encoder from one registered item to its byte sequence
module msghe_encode (
    input  logic [2:0]         i_opcode,
    input  logic [31:0]        i_length,
    input  logic signed [63:0] i_number,
    input  logic [7:0]         i_data_byte,
    output msghe_pkg::t_enc    o_enc
);
    import msghe_pkg::*;

    logic len_le15;
    logic len_le31;
    logic len_le255;
    logic len_le64k;
    logic int_posfix;
    logic int_negfix;
    logic int_fit8;
    logic int_fit16;
    logic int_fit32;

    // length range checks
    assign len_le15  = ~|i_length[31:4];
    assign len_le31  = ~|i_length[31:5];
    assign len_le255 = ~|i_length[31:8];
    assign len_le64k = ~|i_length[31:16];

    // integer range checks: upper bits all copies of the sign
    assign int_posfix = ~|i_number[63:7];
    assign int_negfix = &i_number[63:5];
    assign int_fit8   = (&i_number[63:7])  | (~|i_number[63:7]);
    assign int_fit16  = (&i_number[63:15]) | (~|i_number[63:15]);
    assign int_fit32  = (&i_number[63:31]) | (~|i_number[63:31]);

    // pick the smallest form
    always_comb begin
        o_enc = '0;
        unique case (t_opcode'(i_opcode))
            OP_STR: begin
                priority if (len_le31) begin
                    o_enc.count = CNT_W'(1);
                    o_enc.bytes = {TAG_FIXSTR | {3'b000, i_length[4:0]}, 64'd0};
                end else if (len_le255) begin
                    o_enc.count = CNT_W'(2);
                    o_enc.bytes = {TAG_STR8, i_length[7:0], 56'd0};
                end else if (len_le64k) begin
                    o_enc.count = CNT_W'(3);
                    o_enc.bytes = {TAG_STR16, i_length[15:0], 48'd0};
                end else begin
                    o_enc.count = CNT_W'(5);
                    o_enc.bytes = {TAG_STR32, i_length, 32'd0};
                end
            end
            OP_BIN: begin
                priority if (len_le255) begin
                    o_enc.count = CNT_W'(2);
                    o_enc.bytes = {TAG_BIN8, i_length[7:0], 56'd0};
                end else if (len_le64k) begin
                    o_enc.count = CNT_W'(3);
                    o_enc.bytes = {TAG_BIN16, i_length[15:0], 48'd0};
                end else begin
                    o_enc.count = CNT_W'(5);
                    o_enc.bytes = {TAG_BIN32, i_length, 32'd0};
                end
            end
            OP_INT: begin
                priority if (int_posfix || int_negfix) begin
                    o_enc.count = CNT_W'(1);
                    o_enc.bytes = {i_number[7:0], 64'd0};
                end else if (int_fit8) begin
                    o_enc.count = CNT_W'(2);
                    o_enc.bytes = {TAG_INT8, i_number[7:0], 56'd0};
                end else if (int_fit16) begin
                    o_enc.count = CNT_W'(3);
                    o_enc.bytes = {TAG_INT16, i_number[15:0], 48'd0};
                end else if (int_fit32) begin
                    o_enc.count = CNT_W'(5);
                    o_enc.bytes = {TAG_INT32, i_number[31:0], 32'd0};
                end else begin
                    o_enc.count = CNT_W'(9);
                    o_enc.bytes = {TAG_INT64, i_number};
                end
            end
            OP_ARR: begin
                priority if (len_le15) begin
                    o_enc.count = CNT_W'(1);
                    o_enc.bytes = {TAG_FIXARRAY | {4'b0000, i_length[3:0]}, 64'd0};
                end else if (len_le64k) begin
                    o_enc.count = CNT_W'(3);
                    o_enc.bytes = {TAG_ARRAY16, i_length[15:0], 48'd0};
                end else begin
                    o_enc.count = CNT_W'(5);
                    o_enc.bytes = {TAG_ARRAY32, i_length, 32'd0};
                end
            end
            OP_RAW: begin
                o_enc.count = CNT_W'(1);
                o_enc.bytes = {i_data_byte, 64'd0};
            end
            default: begin
                o_enc = '0;
            end
        endcase
    end

endmodule

### rtl/msghe_serializer.sv
// byte shifter and result register, one byte per cycle
module msghe_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load_valid,
    input  msghe_pkg::t_enc i_enc,
    output logic            o_take,
    output logic            o_strobe,
    output logic [7:0]      o_out_byte,
    output logic            o_last
);
    import msghe_pkg::*;

    logic [BUF_W-1:0] r_buf;
    logic [BUF_W-1:0] n_buf;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             emit;

    // a new item may load while the final byte of the previous one leaves
    assign o_take = (r_cnt <= CNT_W'(1));
    assign emit   = (r_cnt != '0);

    // next shifter contents
    always_comb begin
        priority if (o_take && i_load_valid) begin
            n_buf = i_enc.bytes;
            n_cnt = i_enc.count;
        end else if (emit) begin
            n_buf = {r_buf[BUF_W-9:0], 8'd0};
            n_cnt = r_cnt - CNT_W'(1);
        end else begin
            n_buf = r_buf;
            n_cnt = r_cnt;
        end
    end

    // shifter count and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            o_strobe <= 1'b0;
            o_last   <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            o_strobe <= emit;
            o_last   <= emit && (r_cnt == CNT_W'(1));
        end
    end

    // shifter data and result byte
    always_ff @(posedge i_clk) begin
        r_buf      <= n_buf;
        o_out_byte <= r_buf[BUF_W-1 -: 8];
    end

    // last only marks a real transfer
    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last without strobe");

    // count never exceeds the longest encoding
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_BYTES))
        else $error("byte count out of range");

    // bytes remaining means a non-final transfer next cycle
    a_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > CNT_W'(1)) |=> (o_strobe && !o_last))
        else $error("run ended early");

    // a pending load never overwrites bytes still to go
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > CNT_W'(1)) |=> (r_cnt == $past(r_cnt) - CNT_W'(1)))
        else $error("shifter reloaded mid run");

endmodule

### rtl/msghe_serializer_wrap_note.sv
// input register stage holding one accepted item until the shifter takes it
module msghe_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               i_take,
    input  logic [2:0]         i_opcode,
    input  logic [31:0]        i_length,
    input  logic signed [63:0] i_number,
    input  logic [7:0]         i_data_byte,
    output logic               busy,
    output logic               o_valid,
    output logic [2:0]         o_opcode,
    output logic [31:0]        o_length,
    output logic signed [63:0] o_number,
    output logic [7:0]         o_data_byte
);
    logic accept;

    // stall only while holding an item the shifter cannot take yet
    assign busy   = o_valid && !i_take;
    assign accept = start && !busy;

    // held item valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (accept) begin
            o_valid <= 1'b1;
        end else if (i_take) begin
            o_valid <= 1'b0;
        end
    end

    // held item fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_opcode    <= i_opcode;
            o_length    <= i_length;
            o_number    <= i_number;
            o_data_byte <= i_data_byte;
        end
    end

endmodule

### rtl/msgpack_header_encoder.sv
// top level of the messagepack header and integer encoder
//
// Each transfer (start high while busy is low) carries one command: a string,
// binary or array header, a signed integer, or one raw payload byte. The block
// emits the encoded stream one byte per cycle on o_out_byte with o_strobe high
// for exactly one cycle per byte, and o_last marks the final byte of each
// command. The receiver cannot stall. A command has as many bytes as its
// encoding: one for raw bytes, fix forms and small integers, up to nine for a
// full 64-bit integer. busy is only raised while a multi-byte encoding is still
// draining, so raw payload bytes flow at one per cycle. The first byte of a
// command passes through the input register, the byte shifter and the result
// register after its transfer, and comes later while the previous command is
// still draining its bytes. Unused opcodes produce no bytes.
module msgpack_header_encoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_opcode,
    input  logic [31:0]        i_length,
    input  logic signed [63:0] i_number,
    input  logic [7:0]         i_data_byte,
    output logic               o_strobe,
    output logic [7:0]         o_out_byte,
    output logic               o_last
);
    import msghe_pkg::*;

    logic               take;
    logic               held_valid;
    logic [2:0]         held_opcode;
    logic [31:0]        held_length;
    logic signed [63:0] held_number;
    logic [7:0]         held_data_byte;
    t_enc               enc;

    // input register
    msghe_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_take      (take),
        .i_opcode    (i_opcode),
        .i_length    (i_length),
        .i_number    (i_number),
        .i_data_byte (i_data_byte),
        .busy        (busy),
        .o_valid     (held_valid),
        .o_opcode    (held_opcode),
        .o_length    (held_length),
        .o_number    (held_number),
        .o_data_byte (held_data_byte)
    );

    // smallest-form encoding
    msghe_encode u_enc (
        .i_opcode    (held_opcode),
        .i_length    (held_length),
        .i_number    (held_number),
        .i_data_byte (held_data_byte),
        .o_enc       (enc)
    );

    // byte shifter and result register
    msghe_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (held_valid),
        .i_enc        (enc),
        .o_take       (take),
        .o_strobe     (o_strobe),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last)
    );

endmodule
